// ===== sv/y2r_pkg.sv =====
// Shared types and constants for the packed 4:2:2 to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

    // Byte order codes
    localparam logic BYTE_ORDER_YUYV = 1'b0;
    localparam logic BYTE_ORDER_UYVY = 1'b1;

    // Fixed-point coefficients
    localparam int LUMA_OFFSET   = 16;
    localparam int CHROMA_OFFSET = 128;
    localparam int COEF_Y        = 75;
    localparam int COEF_RV       = 51;
    localparam int COEF_GU       = 13;
    localparam int COEF_GV       = 26;
    localparam int COEF_BU       = 65;
    localparam int LUMA_SHIFT    = 6;
    localparam int CHROMA_SHIFT  = 5;
    localparam int CHAN_MAX      = 255;

    // One packed macropixel as it arrives
    typedef struct packed {
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic       buffer_end;
    } y2r_mpix_t;

    // Stage 1 result: raw products
    typedef struct packed {
        logic signed [15:0] y0_prod;
        logic signed [15:0] y1_prod;
        logic signed [13:0] r_prod;
        logic signed [11:0] gu_prod;
        logic signed [12:0] gv_prod;
        logic signed [14:0] b_prod;
        logic               buffer_end;
    } y2r_prod_t;

    // Stage 2 result: scaled luma and chroma deltas
    typedef struct packed {
        logic signed [9:0] y0_lum;
        logic signed [9:0] y1_lum;
        logic signed [8:0] r_dif;
        logic signed [8:0] g_dif;
        logic signed [9:0] b_dif;
        logic              buffer_end;
    } y2r_term_t;

    // Stage 3 result: two clamped RGB pixels
    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       buffer_end;
    } y2r_pix_t;

endpackage

`default_nettype wire

// ===== sv/y2r_scale.sv =====
// Stage 1: byte unpacking, offset removal and constant multiplies.
`timescale 1ns / 1ps
`default_nettype none

module y2r_scale (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               byte_order,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire y2r_pkg::y2r_mpix_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output y2r_pkg::y2r_prod_t      out_data
);
    import y2r_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    y2r_prod_t         data_reg;
    y2r_prod_t         data_next;
    logic [7:0]        y0_raw;
    logic [7:0]        y1_raw;
    logic [7:0]        u_raw;
    logic [7:0]        v_raw;
    logic signed [8:0] y0_off;
    logic signed [8:0] y1_off;
    logic signed [8:0] u_off;
    logic signed [8:0] v_off;

    always_comb begin
        if (byte_order == BYTE_ORDER_UYVY) begin
            u_raw  = in_data.byte_0;
            y0_raw = in_data.byte_1;
            v_raw  = in_data.byte_2;
            y1_raw = in_data.byte_3;
        end else begin
            y0_raw = in_data.byte_0;
            u_raw  = in_data.byte_1;
            y1_raw = in_data.byte_2;
            v_raw  = in_data.byte_3;
        end
    end

    assign y0_off = $signed({1'b0, y0_raw}) - $signed(9'(LUMA_OFFSET));
    assign y1_off = $signed({1'b0, y1_raw}) - $signed(9'(LUMA_OFFSET));
    assign u_off  = $signed({1'b0, u_raw}) - $signed(9'(CHROMA_OFFSET));
    assign v_off  = $signed({1'b0, v_raw}) - $signed(9'(CHROMA_OFFSET));

    always_comb begin
        data_next.y0_prod    = $signed(16'(y0_off)) * $signed(16'(COEF_Y));
        data_next.y1_prod    = $signed(16'(y1_off)) * $signed(16'(COEF_Y));
        data_next.r_prod     = $signed(14'(v_off)) * $signed(14'(COEF_RV));
        data_next.gu_prod    = $signed(12'(u_off)) * $signed(12'(COEF_GU));
        data_next.gv_prod    = $signed(13'(v_off)) * $signed(13'(COEF_GV));
        data_next.b_prod     = $signed(15'(u_off)) * $signed(15'(COEF_BU));
        data_next.buffer_end = in_data.buffer_end;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/y2r_shift.sv =====
// Stage 2: floor shifts of the products and the combined green delta.
`timescale 1ns / 1ps
`default_nettype none

module y2r_shift (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire y2r_pkg::y2r_prod_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output y2r_pkg::y2r_term_t      out_data
);
    import y2r_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    y2r_term_t         data_reg;
    y2r_term_t         data_next;
    logic signed [6:0] gu_sh;
    logic signed [7:0] gv_sh;

    // Arithmetic shifts on signed values floor toward minus infinity
    assign gu_sh = 7'(in_data.gu_prod >>> CHROMA_SHIFT);
    assign gv_sh = 8'(in_data.gv_prod >>> CHROMA_SHIFT);

    always_comb begin
        data_next.y0_lum     = 10'(in_data.y0_prod >>> LUMA_SHIFT);
        data_next.y1_lum     = 10'(in_data.y1_prod >>> LUMA_SHIFT);
        data_next.r_dif      = 9'(in_data.r_prod >>> CHROMA_SHIFT);
        data_next.g_dif      = 9'sd0 - 9'(gu_sh) - 9'(gv_sh);
        data_next.b_dif      = 10'(in_data.b_prod >>> CHROMA_SHIFT);
        data_next.buffer_end = in_data.buffer_end;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/y2r_clamp.sv =====
// Stage 3: per-channel sums, saturation to 0..255, output register.
`timescale 1ns / 1ps
`default_nettype none

module y2r_clamp (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire y2r_pkg::y2r_term_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output y2r_pkg::y2r_pix_t       out_data
);
    import y2r_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    y2r_pix_t data_reg;
    y2r_pix_t data_next;

    function automatic logic [7:0] sat8(input logic signed [10:0] x);
        logic [7:0] r;
        if (x < 11'sd0) begin
            r = 8'd0;
        end else if (x > $signed(11'(CHAN_MAX))) begin
            r = 8'(CHAN_MAX);
        end else begin
            r = x[7:0];
        end
        return r;
    endfunction

    always_comb begin
        data_next.red_first    = sat8(11'(in_data.y0_lum) + 11'(in_data.r_dif));
        data_next.green_first  = sat8(11'(in_data.y0_lum) + 11'(in_data.g_dif));
        data_next.blue_first   = sat8(11'(in_data.y0_lum) + 11'(in_data.b_dif));
        data_next.red_second   = sat8(11'(in_data.y1_lum) + 11'(in_data.r_dif));
        data_next.green_second = sat8(11'(in_data.y1_lum) + 11'(in_data.g_dif));
        data_next.blue_second  = sat8(11'(in_data.y1_lum) + 11'(in_data.b_dif));
        data_next.buffer_end   = in_data.buffer_end;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/packed_yuv422_to_rgb_converter.sv =====
// Top level of the packed 4:2:2 YCbCr to dual RGB pixel converter.
`timescale 1ns / 1ps
`default_nettype none

// One transaction on the s_ side carries one packed 4:2:2 macropixel (two
// luma samples sharing one chroma pair, in YUYV or UYVY order as set by
// cfg_wdata); one transaction on the m_ side carries the two resulting RGB
// pixels, each channel clamped to 0..255, plus the buffer-end flag. Alpha is
// not produced. The block takes one transaction per clock while the output
// is not stalled; each passes through three register stages (multiply,
// shift/combine, sum/clamp) to m_valid. Each stage holds its own valid bit
// and fills a bubble on its own, so a stalled output stops only the stages
// behind it once they are full; no transaction is dropped or repeated.
// Write the byte order only while the pipeline is empty.

module packed_yuv422_to_rgb_converter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    // macropixel input
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_byte_0,
    input  wire logic [7:0] s_byte_1,
    input  wire logic [7:0] s_byte_2,
    input  wire logic [7:0] s_byte_3,
    input  wire logic       s_buffer_end_in,
    // RGB output
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red_first,
    output logic [7:0]      m_green_first,
    output logic [7:0]      m_blue_first,
    output logic [7:0]      m_red_second,
    output logic [7:0]      m_green_second,
    output logic [7:0]      m_blue_second,
    output logic            m_buffer_end_out
);
    import y2r_pkg::*;

    logic      byte_order_reg;
    logic      byte_order_next;
    y2r_mpix_t in_mpix;
    logic      s1_valid;
    logic      s1_ready;
    y2r_prod_t s1_data;
    logic      s2_valid;
    logic      s2_ready;
    y2r_term_t s2_data;
    y2r_pix_t  s3_data;

    // Byte order register: the user must see that it is written only while idle,
    // as the block does not enforce it; so the stage-1 mux may read it directly.
    assign byte_order_next = cfg_we ? cfg_wdata : byte_order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= BYTE_ORDER_YUYV;
        end else begin
            byte_order_reg <= byte_order_next;
        end
    end

    always_comb begin
        in_mpix.byte_0     = s_byte_0;
        in_mpix.byte_1     = s_byte_1;
        in_mpix.byte_2     = s_byte_2;
        in_mpix.byte_3     = s_byte_3;
        in_mpix.buffer_end = s_buffer_end_in;
    end

    // Stage 1: unpack, remove offsets, constant multiplies
    y2r_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_order(byte_order_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (in_mpix),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage 2: floor shifts, green delta
    y2r_shift u_shift (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid),
        .in_ready (s1_ready),
        .in_data  (s1_data),
        .out_valid(s2_valid),
        .out_ready(s2_ready),
        .out_data (s2_data)
    );

    // Stage 3: sums and saturation; its register drives the m_ ports
    y2r_clamp u_clamp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .in_data  (s2_data),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (s3_data)
    );

    assign m_red_first      = s3_data.red_first;
    assign m_green_first    = s3_data.green_first;
    assign m_blue_first     = s3_data.blue_first;
    assign m_red_second     = s3_data.red_second;
    assign m_green_second   = s3_data.green_second;
    assign m_blue_second    = s3_data.blue_second;
    assign m_buffer_end_out = s3_data.buffer_end;

    // An accepted input transaction always lands in stage 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_valid)
        else $error("accepted transaction missing from stage 1");

    // A stalled stage 1 keeps its transaction and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_data)))
        else $error("stage 1 lost or changed a stalled transaction");

    // A stalled stage 2 keeps its transaction and payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid && !s2_ready) |=> (s2_valid && $stable(s2_data)))
        else $error("stage 2 lost or changed a stalled transaction");

    // Nothing valid leaves the pipeline right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// ===== verif/packed_yuv422_to_rgb_converter_test.sv =====
// Self-checking testbench for the packed 4:2:2 to RGB converter.
`timescale 1ns / 1ps

module packed_yuv422_to_rgb_converter_test;
    import y2r_pkg::*;

    localparam int    CLK_PERIOD_NS  = 12;
    localparam int    RESET_CYCLES   = 6;
    localparam int    DRAIN_CYCLES   = 6;    // pipeline is three stages deep
    localparam int    PHASE_ITEMS    = 300;
    localparam int    NUM_PHASES     = 6;
    localparam int    MAX_REPORTS    = 30;
    localparam longint RUN_LIMIT_NS  = 64'd40_000_000;

    // byte values that sit on or next to the luma/chroma breakpoints
    localparam logic [7:0] CORNER_BYTES [13] = '{
        8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
        8'd129, 8'd234, 8'd235, 8'd236, 8'd254, 8'd255
    };

    // random phase plan: byte order and which side idles
    localparam logic PHASE_ORDER [NUM_PHASES] = '{
        BYTE_ORDER_UYVY, BYTE_ORDER_YUYV, BYTE_ORDER_YUYV,
        BYTE_ORDER_UYVY, BYTE_ORDER_UYVY, BYTE_ORDER_YUYV
    };
    localparam bit PHASE_SRC_IDLE  [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam bit PHASE_SINK_IDLE [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

    typedef struct {
        logic      order;
        y2r_mpix_t mp;
        bit        known;   // expected pixels typed in below
        y2r_pix_t  typed;
    } stim_row_t;

    logic       aclk            = 1'b0;
    logic       aresetn         = 1'b0;
    logic       cfg_we          = 1'b0;
    logic       cfg_wdata       = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_0        = 8'd0;
    logic [7:0] s_byte_1        = 8'd0;
    logic [7:0] s_byte_2        = 8'd0;
    logic [7:0] s_byte_3        = 8'd0;
    logic       s_buffer_end_in = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic [7:0] m_red_first;
    logic [7:0] m_green_first;
    logic [7:0] m_blue_first;
    logic [7:0] m_red_second;
    logic [7:0] m_green_second;
    logic [7:0] m_blue_second;
    logic       m_buffer_end_out;

    y2r_pix_t  pending_pixels [$];   // expected pixel pairs, oldest first
    stim_row_t directed_plan  [$];
    logic      byte_order_cfg = BYTE_ORDER_YUYV;   // testbench copy of the register
    bit        src_idle_on    = 1'b0;
    bit        sink_idle_on   = 1'b0;
    int        sink_stall_left = 0;
    int        mismatch_count = 0;
    int        mpix_sent      = 0;
    int        pairs_seen     = 0;
    int        end_flags_seen = 0;
    int        cfg_writes     = 0;
    int        directed_count = 0;

    packed_yuv422_to_rgb_converter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_byte_0         (s_byte_0),
        .s_byte_1         (s_byte_1),
        .s_byte_2         (s_byte_2),
        .s_byte_3         (s_byte_3),
        .s_buffer_end_in  (s_buffer_end_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_red_first      (m_red_first),
        .m_green_first    (m_green_first),
        .m_blue_first     (m_blue_first),
        .m_red_second     (m_red_second),
        .m_green_second   (m_green_second),
        .m_blue_second    (m_blue_second),
        .m_buffer_end_out (m_buffer_end_out)
    );

    initial begin
        forever #(CLK_PERIOD_NS / 2) aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic logic [7:0] clamp_channel(input int level);
        if (level < 0)
            return 8'd0;
        if (level > CHAN_MAX)
            return 8'(CHAN_MAX);
        return 8'(level);
    endfunction

    // Two RGB pixels from one macropixel. >>> on int is a floor divide.
    function automatic y2r_pix_t convert_macropixel(input y2r_mpix_t mp, input logic order);
        int       luma0, luma1, cb, cr;
        int       red_d, green_d, blue_d;
        y2r_pix_t px;
        if (order == BYTE_ORDER_UYVY) begin
            cb = mp.byte_0; luma0 = mp.byte_1; cr = mp.byte_2; luma1 = mp.byte_3;
        end else begin
            luma0 = mp.byte_0; cb = mp.byte_1; luma1 = mp.byte_2; cr = mp.byte_3;
        end
        luma0 = (COEF_Y * (luma0 - LUMA_OFFSET)) >>> LUMA_SHIFT;
        luma1 = (COEF_Y * (luma1 - LUMA_OFFSET)) >>> LUMA_SHIFT;
        cb    = cb - CHROMA_OFFSET;
        cr    = cr - CHROMA_OFFSET;
        red_d   = (COEF_RV * cr) >>> CHROMA_SHIFT;
        green_d = -((COEF_GU * cb) >>> CHROMA_SHIFT) - ((COEF_GV * cr) >>> CHROMA_SHIFT);
        blue_d  = (COEF_BU * cb) >>> CHROMA_SHIFT;
        px.red_first    = clamp_channel(luma0 + red_d);
        px.green_first  = clamp_channel(luma0 + green_d);
        px.blue_first   = clamp_channel(luma0 + blue_d);
        px.red_second   = clamp_channel(luma1 + red_d);
        px.green_second = clamp_channel(luma1 + green_d);
        px.blue_second  = clamp_channel(luma1 + blue_d);
        px.buffer_end   = mp.buffer_end;
        return px;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) < 3)
            return CORNER_BYTES[$urandom_range(0, 12)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic y2r_mpix_t make_mpix(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic be);
        return '{byte_0: b0, byte_1: b1, byte_2: b2, byte_3: b3, buffer_end: be};
    endfunction

    function automatic void add_row(input logic order, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic [7:0] b3, input logic be);
        stim_row_t row;
        row.order = order;
        row.mp    = make_mpix(b0, b1, b2, b3, be);
        row.known = 1'b0;
        row.typed = '0;
        directed_plan.push_back(row);
    endfunction

    // Rows whose pixels are plain grey: every channel of a pixel at one level.
    function automatic void add_grey_row(input logic order, input logic [7:0] b0,
                                         input logic [7:0] b1, input logic [7:0] b2,
                                         input logic [7:0] b3, input logic be,
                                         input logic [7:0] first_lvl,
                                         input logic [7:0] second_lvl);
        stim_row_t row;
        row.order = order;
        row.mp    = make_mpix(b0, b1, b2, b3, be);
        row.known = 1'b1;
        row.typed = '{red_first: first_lvl, green_first: first_lvl, blue_first: first_lvl,
                      red_second: second_lvl, green_second: second_lvl,
                      blue_second: second_lvl, buffer_end: be};
        directed_plan.push_back(row);
    endfunction

    // One input transaction. Called right at the edge the previous one was
    // taken, so valid either stays up with a new payload or drops for a gap.
    task automatic send_mpix(input y2r_mpix_t mp, input bit known, input y2r_pix_t typed);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_byte_0        <= mp.byte_0;
        s_byte_1        <= mp.byte_1;
        s_byte_2        <= mp.byte_2;
        s_byte_3        <= mp.byte_3;
        s_buffer_end_in <= mp.buffer_end;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_pixels.push_back(known ? typed : convert_macropixel(mp, byte_order_cfg));
        mpix_sent++;
    endtask

    // Byte order changes only with the pipeline empty.
    task automatic set_byte_order(input logic order);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= order;
        @(posedge aclk);
        cfg_we         <= 1'b0;
        byte_order_cfg  = order;
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (sink_stall_left > 0) begin
            m_ready         <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 99) < 25) begin
            m_ready         <= 1'b0;
            sink_stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("pair %0d %s got %0d want %0d",
                                      pairs_seen, name, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        y2r_pix_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pair %0d arrived with nothing pending",
                                          pairs_seen));
            end else begin
                want = pending_pixels.pop_front();
                check_field("red_first",    m_red_first,    want.red_first);
                check_field("green_first",  m_green_first,  want.green_first);
                check_field("blue_first",   m_blue_first,   want.blue_first);
                check_field("red_second",   m_red_second,   want.red_second);
                check_field("green_second", m_green_second, want.green_second);
                check_field("blue_second",  m_blue_second,  want.blue_second);
                check_field("buffer_end",   {7'd0, m_buffer_end_out}, {7'd0, want.buffer_end});
            end
            if (m_buffer_end_out === 1'b1)
                end_flags_seen++;
            pairs_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial begin
        y2r_mpix_t mp;

        // YUYV rows first, relying on the reset byte order.
        // black, white, and clamping of the luma extremes on each pixel
        add_grey_row(BYTE_ORDER_YUYV,  8'd16, 8'd128,  8'd16, 8'd128, 1'b0, 8'd0,   8'd0);
        add_grey_row(BYTE_ORDER_YUYV, 8'd235, 8'd128, 8'd235, 8'd128, 1'b1, 8'd255, 8'd255);
        add_grey_row(BYTE_ORDER_YUYV,   8'd0, 8'd128, 8'd255, 8'd128, 1'b0, 8'd0,   8'd255);
        add_grey_row(BYTE_ORDER_YUYV, 8'd255, 8'd128,   8'd0, 8'd128, 1'b1, 8'd255, 8'd0);
        add_row(BYTE_ORDER_YUYV,   8'd0,   8'd0,   8'd0,   8'd0, 1'b0);
        add_row(BYTE_ORDER_YUYV, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_row(BYTE_ORDER_YUYV, 8'd128,   8'd0, 8'd128, 8'd255, 1'b0);  // chroma extremes
        add_row(BYTE_ORDER_YUYV, 8'd128, 8'd255, 8'd128,   8'd0, 1'b0);
        add_row(BYTE_ORDER_YUYV,  8'd16, 8'd240, 8'd235,  8'd16, 1'b0);
        add_row(BYTE_ORDER_YUYV,  8'd81, 8'd127,  8'd81, 8'd127, 1'b0);  // floor of small negatives
        add_row(BYTE_ORDER_YUYV,  8'd15, 8'd129,  8'd17, 8'd129, 1'b1);
        // same shapes with UYVY ordering
        add_grey_row(BYTE_ORDER_UYVY, 8'd128,  8'd16, 8'd128,  8'd16, 1'b0, 8'd0,   8'd0);
        add_grey_row(BYTE_ORDER_UYVY, 8'd128, 8'd235, 8'd128, 8'd235, 1'b1, 8'd255, 8'd255);
        add_grey_row(BYTE_ORDER_UYVY, 8'd128,   8'd0, 8'd128, 8'd255, 1'b0, 8'd0,   8'd255);
        add_row(BYTE_ORDER_UYVY,   8'd0,   8'd0,   8'd0,   8'd0, 1'b1);
        add_row(BYTE_ORDER_UYVY, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        add_row(BYTE_ORDER_UYVY,   8'd0, 8'd128, 8'd255, 8'd128, 1'b0);
        add_row(BYTE_ORDER_UYVY, 8'd255, 8'd128,   8'd0, 8'd128, 1'b1);
        add_row(BYTE_ORDER_UYVY, 8'd127, 8'd100, 8'd127, 8'd100, 1'b0);
        // back to YUYV to check the register goes both ways
        add_row(BYTE_ORDER_YUYV, 8'd170,  8'd85, 8'd170,  8'd85, 1'b1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        foreach (directed_plan[i]) begin
            if (directed_plan[i].order !== byte_order_cfg)
                set_byte_order(directed_plan[i].order);
            send_mpix(directed_plan[i].mp, directed_plan[i].known, directed_plan[i].typed);
        end
        directed_count = mpix_sent;

        // Random phases; every phase rewrites the register, including
        // back-to-back writes of the same value.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_byte_order(PHASE_ORDER[ph]);
            src_idle_on  = PHASE_SRC_IDLE[ph];
            sink_idle_on = PHASE_SINK_IDLE[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                mp = make_mpix(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                               ($urandom_range(0, 9) == 0));
                send_mpix(mp, 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d macropixels (%0d directed, %0d random) across %0d byte-order writes",
                 mpix_sent, directed_count, mpix_sent - directed_count, cfg_writes);
        $display("Checked %0d RGB pixel pairs, %0d with buffer end set, %0d mismatches",
                 pairs_seen, end_flags_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("packed_yuv422_to_rgb_converter test passed");
        else
            $display("packed_yuv422_to_rgb_converter test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d pixel pairs still pending", pending_pixels.size());
        $display("packed_yuv422_to_rgb_converter test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/y2r_pkg.sv
sv/y2r_scale.sv
sv/y2r_shift.sv
sv/y2r_clamp.sv
sv/packed_yuv422_to_rgb_converter.sv
verif/packed_yuv422_to_rgb_converter_test.sv
